// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, quiet while reset is held.
`define SIT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion, also checked during reset.
`define SIT_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sit_pkg.sv =====
// Widths, types and arithmetic helpers for the segment intersection test.
package sit_pkg;

  localparam int CW          = 16;               // coordinate width
  localparam int DW          = CW + 1;           // coordinate difference
  localparam int PW          = 2 * DW;           // product of two differences
  localparam int XW          = PW + 1;           // cross or dot result
  localparam int NUM_COORDS  = 8;
  localparam int IN_TDATA_W  = ((NUM_COORDS * CW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [XW-1:0] acc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  function automatic vec_t vsub(pt_t p, pt_t q);
    vec_t r;
    r.x = diff_t'(p.x) - diff_t'(q.x);
    r.y = diff_t'(p.y) - diff_t'(q.y);
    return r;
  endfunction

  function automatic acc_t vcross(vec_t p, vec_t q);
    prod_t m1;
    prod_t m2;
    m1 = prod_t'(p.x) * prod_t'(q.y);
    m2 = prod_t'(p.y) * prod_t'(q.x);
    return acc_t'(m1) - acc_t'(m2);
  endfunction

  function automatic acc_t vdot(vec_t p, vec_t q);
    prod_t m1;
    prod_t m2;
    m1 = prod_t'(p.x) * prod_t'(q.x);
    m2 = prod_t'(p.y) * prod_t'(q.y);
    return acc_t'(m1) + acc_t'(m2);
  endfunction

  function automatic logic pos(acc_t v);
    return !v[XW-1] && (|v);
  endfunction

  // Signs of both values are strictly equal and nonzero.
  function automatic logic same_sign(acc_t a, acc_t b);
    return (|a) && (|b) && (a[XW-1] == b[XW-1]);
  endfunction

endpackage

// ===== design/segment_intersection_test.sv =====
// Segment intersection test: top level with input and result registers.
// Takes one pair of segments AB and CD per transaction and returns parallel, collinear and
// intersects flags with exact integer arithmetic. Each pair passes the input register, then the
// result register; a new pair is accepted every cycle while the result side keeps up. All
// sixteen products are computed side by side between the two registers. in_tdata holds ax, ay,
// bx, by_coord, cx, cy, dx, dy from bit 0 up, 16 bits each; out_tdata bit 0 is parallel, bit 1
// collinear, bit 2 intersects.
module segment_intersection_test (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy (lowest first)
  input  logic [sit_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // parallel, collinear, intersects (lowest first), zero filled
  output logic [sit_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sit_pkg::*;

  logic                        in_vld_r;
  logic [NUM_COORDS*CW-1:0]    in_data_r;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  logic [2:0]                  flags_r;
  logic [2:0]                  flags_nxt;
  logic                        out_load;
  logic                        in_load;

  pt_t  a, b, c, d;
  vec_t ab, cd;
  acc_t par_x, o1, o2, o3, o4, d1, d2, d3;
  logic par, col, same_any, hit_col, hit_gen, hit;

  assign out_load  = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_data_r <= in_tdata[NUM_COORDS*CW-1:0];
    end
    if (out_load && in_vld_r) begin
      flags_r <= flags_nxt;
    end
  end

  assign out_vld_nxt = out_load ? in_vld_r : out_vld_r;

  always_comb begin
    a.x = coord_t'(in_data_r[0*CW +: CW]);
    a.y = coord_t'(in_data_r[1*CW +: CW]);
    b.x = coord_t'(in_data_r[2*CW +: CW]);
    b.y = coord_t'(in_data_r[3*CW +: CW]);
    c.x = coord_t'(in_data_r[4*CW +: CW]);
    c.y = coord_t'(in_data_r[5*CW +: CW]);
    d.x = coord_t'(in_data_r[6*CW +: CW]);
    d.y = coord_t'(in_data_r[7*CW +: CW]);

    ab = vsub(b, a);
    cd = vsub(d, c);

    par_x = vcross(ab, vsub(c, d));
    // o2 and o3 are, up to sign, the two collinearity crosses
    o1 = vcross(vsub(d, a), ab);
    o2 = vcross(vsub(c, a), ab);
    o3 = vcross(vsub(a, c), cd);
    o4 = vcross(vsub(b, c), cd);

    d1 = vdot(vsub(c, a), vsub(c, b));
    d2 = vdot(vsub(d, a), vsub(d, b));
    d3 = vdot(vsub(c, b), vsub(d, b));

    par = ~(|par_x);
    col = par && ~(|o2) && ~(|o3);

    same_any = (a == c) || (a == d) || (b == c) || (b == d);
    // collinear: miss only when both of C, D lie beyond the same end of AB
    hit_col  = same_any || !(pos(d1) && pos(d2) && pos(d3));
    hit_gen  = !(same_sign(o1, o2) || same_sign(o3, o4));
    hit      = col ? hit_col : hit_gen;

    flags_nxt = {hit, col, par};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(flags_r);

endmodule

// ===== design/sit_checker.sv =====
// Port-level checker for the segment intersection test, bound to the top level.
`include "assert_macros.svh"

module sit_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sit_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sit_pkg::*;

  `SIT_ASSERT(a_rst_clears, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `SIT_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `SIT_ASSERT_RST(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[OUT_TDATA_W-1:3] == '0, "fill bits not zero")
  `SIT_ASSERT_RST(a_col_par, clk, rst_n, out_tvalid && out_tdata[1] |-> out_tdata[0], "collinear without parallel")
  `SIT_ASSERT_RST(a_latency, clk, rst_n, in_tvalid && in_tready ##1 out_tready |=> out_tvalid, "transaction lost in pipeline")

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);
